// ----- sv/ready_queue_scheduler_defines.svh -----
// Assertion macros used by the ready queue scheduler checker
`ifndef READY_QUEUE_SCHEDULER_DEFINES_SVH
`define READY_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RQS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rqs_pkg.sv -----
// Shared types and constants of the ready queue scheduler
package rqs_pkg;

    localparam int QueueDepthDefault = 16;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int LVL_W   = 5;
    localparam int MODE_W  = 2;
    localparam int QCNT_W  = 5;

    // Policy codes
    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

    // Item kinds
    localparam logic KIND_ENQ   = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    // One queued job
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [LVL_W-1:0]   level;
    } t_entry;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    // Chosen job as seen by the sequencer
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] level;
    } t_pick;

endpackage

// ----- sv/ready_queue_scheduler.sv -----
// An enqueue or an empty schedule goes from the done state into the output register. A schedule
// first makes a full rotation of the cell row past the single pick unit, then a shift to close the
// gap, then the load into the output register.
// A new word is taken once the previous one is in the output register; a stalled result word
// holds off both enqueues and schedules.
// Synchronous active-low reset empties the queue, clears level and policy; no word is taken.
module ready_queue_scheduler
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MODE_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_job_id,
    input  logic [BURST_W-1:0] i_burst_time,
    input  logic [LVL_W-1:0]   i_job_priority,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ID_W-1:0]    o_picked_id,
    output logic               o_picked,
    output logic               o_rejected,
    output logic [QCNT_W-1:0]  o_queue_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_REMOVE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [LVL_W-1:0]    r_cur_level;
    logic [LVL_W-1:0]    n_cur_level;
    logic [MODE_W-1:0]   r_mode;
    logic [IW-1:0]       r_k;
    logic [IW-1:0]       n_k;
    logic [ID_W-1:0]     r_res_id;
    logic [ID_W-1:0]     n_res_id;
    logic                r_res_picked;
    logic                n_res_picked;
    logic                r_res_rejected;
    logic                n_res_rejected;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_picked;
    logic                r_out_rejected;
    logic [CW-1:0]       r_out_count;

    logic                w_in_acc;
    logic                w_full;
    logic                w_out_load;
    t_cell_op            w_op;
    t_entry              w_load;
    t_entry              w_entry [QUEUE_DEPTH];
    logic [IW-1:0]       w_sel_idx;
    t_pick               w_pick;
    logic [CW+QCNT_W-1:0] w_count_ext;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == FULL_CNT);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_load     = '{id: i_job_id, burst: i_burst_time, level: i_job_priority};

    // Drive the cell row
    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_kind == KIND_ENQ) && !w_full) begin
                    w_op = OP_LOAD;
                end else begin
                    w_op = OP_HOLD;
                end
            end
            S_SCAN:   w_op = OP_ROTATE;
            S_REMOVE: w_op = OP_REMOVE;
            default:  w_op = OP_HOLD;
        endcase
    end

    // Row of cells closed into a ring; cell 0 is the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam int NXT = (g + 1) % QUEUE_DEPTH;
        rqs_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_count (r_count),
            .i_sel   (w_sel_idx),
            .i_load  (w_load),
            .i_next  (w_entry[NXT]),
            .o_entry (w_entry[g])
        );
    end

    rqs_scan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_state == S_SCAN),
        .i_first     (r_k == '0),
        .i_live      (CW'(r_k) < r_count),
        .i_idx       (r_k),
        .i_head      (w_entry[0]),
        .i_cur_level (r_cur_level),
        .i_mode      (r_mode),
        .o_sel_idx   (w_sel_idx),
        .o_pick      (w_pick)
    );

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_cur_level    = r_cur_level;
        n_k            = r_k;
        n_res_id       = r_res_id;
        n_res_picked   = r_res_picked;
        n_res_rejected = r_res_rejected;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_id       = '0;
                    n_res_picked   = 1'b0;
                    n_res_rejected = 1'b0;
                    n_k            = '0;
                    if (i_kind == KIND_ENQ) begin
                        if (w_full) begin
                            n_res_rejected = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == LAST_IDX) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                n_count      = r_count - 1'b1;
                n_res_id     = w_pick.id;
                n_res_picked = 1'b1;
                if (r_mode == MODE_PRIO) begin
                    n_cur_level = w_pick.level;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished word, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_level <= '0;
            r_mode      <= MODE_FCFS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_level <= n_cur_level;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k            <= n_k;
        r_res_id       <= n_res_id;
        r_res_picked   <= n_res_picked;
        r_res_rejected <= n_res_rejected;
        if (w_out_load) begin
            r_out_id       <= r_res_id;
            r_out_picked   <= r_res_picked;
            r_out_rejected <= r_res_rejected;
            r_out_count    <= r_count;
        end
    end

    assign w_count_ext   = {{QCNT_W{1'b0}}, r_out_count};
    assign o_out_valid   = r_out_valid;
    assign o_picked_id   = r_out_id;
    assign o_picked      = r_out_picked;
    assign o_rejected    = r_out_rejected;
    assign o_queue_count = w_count_ext[QCNT_W-1:0];

endmodule

// ----- sv/rqs_cell.sv -----
// One queue slot: loads a new job, or takes its neighbour's job when the row moves
module rqs_cell
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int CELL_IDX    = 0,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int IW = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [CW-1:0] i_count,
    input  logic [IW-1:0] i_sel,
    input  t_entry        i_load,
    input  t_entry        i_next,
    output t_entry        o_entry
);

    localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    t_entry r_entry;
    t_entry n_entry;

    // Pick the slot's next content
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            OP_LOAD: begin
                if (i_count == MY_CNT) begin
                    n_entry = i_load;
                end
            end
            OP_ROTATE: begin
                n_entry = i_next;
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_sel) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- sv/rqs_scan.sv -----
// Serial pick unit: watches the head cell while the row rotates and keeps the best job
module rqs_scan
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    localparam int IW = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_first,
    input  logic              i_live,
    input  logic [IW-1:0]     i_idx,
    input  t_entry            i_head,
    input  logic [LVL_W-1:0]  i_cur_level,
    input  logic [MODE_W-1:0] i_mode,
    output logic [IW-1:0]     o_sel_idx,
    output t_pick             o_pick
);

    // Shortest burst so far
    logic [BURST_W-1:0] r_sjf_burst;
    logic [IW-1:0]      r_sjf_idx;
    logic [ID_W-1:0]    r_sjf_id;
    // Lowest level at or above the current level
    logic               r_hi_found;
    logic               n_hi_found;
    logic [LVL_W-1:0]   r_hi_lvl;
    logic [IW-1:0]      r_hi_idx;
    logic [ID_W-1:0]    r_hi_id;
    // Lowest level overall, the fallback
    logic [LVL_W-1:0]   r_lo_lvl;
    logic [IW-1:0]      r_lo_idx;
    logic [ID_W-1:0]    r_lo_id;
    // Front job
    logic [ID_W-1:0]    r_fc_id;

    logic take_sjf;
    logic take_hi;
    logic take_lo;

    // Strict compares keep the earliest job on a tie
    assign take_sjf = i_first || (i_live && (i_head.burst < r_sjf_burst));
    assign take_lo  = i_first || (i_live && (i_head.level < r_lo_lvl));
    assign take_hi  = i_live && (i_head.level >= i_cur_level) &&
                      (i_first || !r_hi_found || (i_head.level < r_hi_lvl));
    assign n_hi_found = i_first ? take_hi : (r_hi_found || take_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_found <= 1'b0;
        end else if (i_step) begin
            r_hi_found <= n_hi_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (take_sjf) begin
                r_sjf_burst <= i_head.burst;
                r_sjf_idx   <= i_idx;
                r_sjf_id    <= i_head.id;
            end
            if (take_hi) begin
                r_hi_lvl <= i_head.level;
                r_hi_idx <= i_idx;
                r_hi_id  <= i_head.id;
            end
            if (take_lo) begin
                r_lo_lvl <= i_head.level;
                r_lo_idx <= i_idx;
                r_lo_id  <= i_head.id;
            end
            if (i_first) begin
                r_fc_id <= i_head.id;
            end
        end
    end

    // Select by policy; FCFS and the unused code serve the front job
    always_comb begin
        case (i_mode)
            MODE_SJF: begin
                o_sel_idx = r_sjf_idx;
                o_pick    = '{id: r_sjf_id, level: i_cur_level};
            end
            MODE_PRIO: begin
                if (r_hi_found) begin
                    o_sel_idx = r_hi_idx;
                    o_pick    = '{id: r_hi_id, level: r_hi_lvl};
                end else begin
                    o_sel_idx = r_lo_idx;
                    o_pick    = '{id: r_lo_id, level: r_lo_lvl};
                end
            end
            default: begin
                o_sel_idx = '0;
                o_pick    = '{id: r_fc_id, level: i_cur_level};
            end
        endcase
    end

endmodule

// ----- sv/rqs_checker.sv -----
// Port-level checks of the ready queue scheduler and their binding
`include "ready_queue_scheduler_defines.svh"

module rqs_checker
    import rqs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [ID_W-1:0]    o_picked_id,
    input logic               o_picked,
    input logic               o_rejected,
    input logic [QCNT_W-1:0]  o_queue_count
);

    // A word either picks a job, rejects an enqueue, or does neither
    `RQS_ASSERT_IMPLY(a_pick_xor_reject, o_out_valid, !(o_picked && o_rejected), "pick and reject together")

    // No pick means a zero id
    `RQS_ASSERT_IMPLY(a_no_pick_zero_id, o_out_valid && !o_picked, o_picked_id == '0, "id without a pick")

    // Busy after taking a word
    `RQS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "second word taken at once")

    // A stalled result word holds
    `RQS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_picked_id) && $stable(o_picked) && $stable(o_rejected) && $stable(o_queue_count), "stalled word changed")

endmodule

bind ready_queue_scheduler rqs_checker u_rqs_checker (.*);
